@@ src/psc_pkg.sv @@
`default_nettype none

package psc_pkg;

    // Default depth of the history line behind the end report.
    localparam int BACK_SAMPLES_DEF = 20;

    localparam int CODE_W     = 16;
    localparam int TIME_W     = 32;
    localparam int CNT_W      = 32;
    localparam int MAG_W      = CODE_W + 1;
    localparam int THR_W      = 15;
    localparam int REL_W      = 4;
    localparam int WIN_W      = 16;
    localparam int OFFSET_W   = 17;
    localparam int GAIN_W     = 21;
    localparam int MARKS      = 4;
    localparam int MARK_IDX_W = 2;

    localparam int IN_DATA_W  = CODE_W + TIME_W;
    localparam int OUT_DATA_W = 192;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    // Calibration arithmetic.
    localparam int PROD_W      = GAIN_W + CODE_W;
    localparam int SUM_W       = PROD_W + 1;
    localparam int FRAC_BITS   = 16;
    localparam int ROUND_HALF  = 32768;
    localparam int MV_W        = SUM_W - FRAC_BITS;
    localparam int VOLTS_W     = 18;
    localparam int VOLTS_MAX   = 131071;
    localparam int VOLTS_MIN   = -131072;
    localparam int PCT_W       = 7;
    localparam int PCT_LO_MV   = 8000;
    localparam int PCT_HI_MV   = 16000;
    localparam int PCT_FULL    = 100;
    localparam int PCT_BIAS    = 7960;   // 8000 minus half a step of 80
    localparam int PCT_X_W     = 13;
    localparam int PCT_RECIP   = 26215;  // ceil(2^21 / 80), exact for x below 43690
    localparam int PCT_RECIP_W = 15;
    localparam int PCT_PROD_W  = PCT_X_W + PCT_RECIP_W;
    localparam int PCT_SHIFT   = 21;

    localparam logic [REL_W-1:0] LOW_RUN_MAX = 4'd15;

    localparam logic [10:0] MARK_MS [0:MARKS-1] = '{11'd200, 11'd500, 11'd1000, 11'd2000};

    // Register reset values.
    localparam logic [THR_W-1:0]           THR_RST    = 15'd160;
    localparam logic [REL_W-1:0]           REL_RST    = 4'd3;
    localparam logic [WIN_W-1:0]           WSTART_RST = 16'd100;
    localparam logic [WIN_W-1:0]           WEND_RST   = 16'd500;
    localparam logic signed [OFFSET_W-1:0] OFFSET_RST = 17'sd10483;
    localparam logic signed [GAIN_W-1:0]   GAIN_RST   = 21'sd18044;

    typedef enum logic [1:0] {
        EV_START   = 2'd0,
        EV_MARK    = 2'd1,
        EV_DISPLAY = 2'd2,
        EV_END     = 2'd3
    } ev_code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD   = 3'd0,
        CFG_RELEASE     = 3'd1,
        CFG_WIN_START   = 3'd2,
        CFG_WIN_END     = 3'd3,
        CFG_VOLT_OFFSET = 3'd4,
        CFG_VOLT_GAIN   = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [THR_W-1:0] threshold;
        logic [REL_W-1:0] release_count;
        logic [WIN_W-1:0] win_start;
        logic [WIN_W-1:0] win_end;
    } trk_cfg_t;

    typedef struct packed {
        logic signed [OFFSET_W-1:0] offset_mv;
        logic signed [GAIN_W-1:0]   gain_q16;
    } cal_cfg_t;

    typedef struct packed {
        logic             fin;
        logic             disp;
        logic [MARKS-1:0] marks;
        logic             start;
    } ev_flags_t;

    typedef struct packed {
        ev_flags_t                flags;
        logic [CNT_W-1:0]         press_number;
        logic signed [CODE_W-1:0] sample_code;
        logic signed [CODE_W-1:0] disp_code;
        logic [TIME_W-1:0]        duration;
        logic [CNT_W-1:0]         sample_count;
        logic signed [CODE_W-1:0] first_code;
        logic signed [CODE_W-1:0] peak_code;
        logic signed [CODE_W-1:0] end_code;
    } bundle_t;

    typedef struct packed {
        bundle_t                   evt;
        logic signed [VOLTS_W-1:0] volts_mv;
        logic [PCT_W-1:0]          percent;
    } res_bundle_t;

    function automatic logic [MAG_W-1:0] code_mag(input logic signed [CODE_W-1:0] v);
        logic signed [MAG_W-1:0] w;
        w = MAG_W'(v);
        code_mag = w[MAG_W-1] ? MAG_W'(-w) : MAG_W'(w);
    endfunction

endpackage

`default_nettype wire

@@ src/press_sample_capture.sv @@
`default_nettype none

// Press sample capture. Each item on the s_ channel is one signed ADC code with its
// millisecond timestamp; the block tracks presses and reports press start, the codes at
// the 200/500/1000/2000 ms marks, the calibrated display value and the press end on the
// m_ channel, one result per item there, m_tlast marking the last result of an input item
// and m_tuser giving the event kind. An input item can be taken in every cycle unless
// back-pressure holds the tracker's output; it passes an input register, the press tracker,
// the two-stage millivolt/percent converter and the result register before its first result
// appears. An input item yields zero to five results, and the result side takes the next item
// only as the last result of the current one is taken. The configuration port is always ready
// and must be written only while no item is in flight.
module press_sample_capture import psc_pkg::*; #(
    parameter int BACK_SAMPLES = BACK_SAMPLES_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // sample_code, time_ms
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // press_number, mark_index, value_code,
                                                  // volts_mv, percent, duration_ms,
                                                  // sample_count, first_code, peak_code,
                                                  // end_code
    output logic [1:0]                 m_tuser,   // event_res
    output logic                       m_tlast,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    trk_cfg_t    trk_cfg;
    cal_cfg_t    cal_cfg;
    logic        trk_valid, trk_ready;
    bundle_t     trk_bundle;
    logic        cnv_valid, cnv_ready;
    res_bundle_t cnv_bundle;

    psc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .trk_cfg   (trk_cfg),
        .cal_cfg   (cal_cfg)
    );

    psc_tracker #(
        .BACK_SAMPLES (BACK_SAMPLES)
    ) u_tracker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (trk_cfg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .out_valid  (trk_valid),
        .out_ready  (trk_ready),
        .out_bundle (trk_bundle)
    );

    psc_convert u_convert (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cal_cfg),
        .in_valid   (trk_valid),
        .in_ready   (trk_ready),
        .in_bundle  (trk_bundle),
        .out_valid  (cnv_valid),
        .out_ready  (cnv_ready),
        .out_bundle (cnv_bundle)
    );

    psc_serializer u_serializer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cnv_valid),
        .in_ready  (cnv_ready),
        .in_bundle (cnv_bundle),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

@@ src/psc_cfg_regs.sv @@
`default_nettype none

module psc_cfg_regs import psc_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output trk_cfg_t                   trk_cfg,
    output cal_cfg_t                   cal_cfg
);

    trk_cfg_t trk_reg, trk_next;
    cal_cfg_t cal_reg, cal_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        trk_next = trk_reg;
        cal_next = cal_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_THRESHOLD:   trk_next.threshold     = cfg_data[THR_W-1:0];
                CFG_RELEASE:     trk_next.release_count = cfg_data[REL_W-1:0];
                CFG_WIN_START:   trk_next.win_start     = cfg_data[WIN_W-1:0];
                CFG_WIN_END:     trk_next.win_end       = cfg_data[WIN_W-1:0];
                CFG_VOLT_OFFSET: cal_next.offset_mv     = cfg_data[OFFSET_W-1:0];
                CFG_VOLT_GAIN:   cal_next.gain_q16      = cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trk_reg.threshold     <= THR_RST;
            trk_reg.release_count <= REL_RST;
            trk_reg.win_start     <= WSTART_RST;
            trk_reg.win_end       <= WEND_RST;
            cal_reg.offset_mv     <= OFFSET_RST;
            cal_reg.gain_q16      <= GAIN_RST;
        end else begin
            trk_reg <= trk_next;
            cal_reg <= cal_next;
        end
    end

    assign trk_cfg = trk_reg;
    assign cal_cfg = cal_reg;

endmodule

`default_nettype wire

@@ src/psc_tracker.sv @@
`default_nettype none

module psc_tracker import psc_pkg::*; #(
    parameter int BACK_SAMPLES = BACK_SAMPLES_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire trk_cfg_t             cfg,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [IN_DATA_W-1:0] s_tdata,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output bundle_t                   out_bundle
);

    localparam int FILL_W = $clog2(BACK_SAMPLES + 2);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(BACK_SAMPLES + 1);

    // Input register.
    logic                     in_valid_reg, in_valid_next;
    logic signed [CODE_W-1:0] in_code_reg;
    logic [TIME_W-1:0]        in_time_reg;

    // Press state.
    logic                     active_reg, active_next;
    logic [CNT_W-1:0]         press_reg, press_next;
    logic [TIME_W-1:0]        start_reg, start_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic signed [CODE_W-1:0] first_reg, first_next;
    logic signed [CODE_W-1:0] peak_reg, peak_next;
    logic [MARKS-1:0]         marks_reg, marks_next;
    logic signed [CODE_W-1:0] wval_reg, wval_next;
    logic                     wvalid_reg, wvalid_next;
    logic                     ddone_reg, ddone_next;
    logic [REL_W-1:0]         low_run_reg, low_run_next;
    logic [FILL_W-1:0]        fill_reg, fill_next;
    logic signed [CODE_W-1:0] tap_reg [0:BACK_SAMPLES];

    logic    out_valid_reg, out_valid_next;
    bundle_t out_bundle_reg, out_bundle_next;

    logic                     b_ready, in_take;
    logic [MAG_W-1:0]         mag;
    logic                     high, starting, sample, low_path, ending;
    logic [TIME_W-1:0]        e_start, t;
    logic [CNT_W-1:0]         e_count, e_press;
    logic signed [CODE_W-1:0] e_peak, e_first, e_wval;
    logic [MARKS-1:0]         e_marks, mark_fire;
    logic                     e_wvalid, e_ddone, win_upd, wvalid_new, disp_s;
    logic [FILL_W-1:0]        e_fill;
    logic [REL_W-1:0]         low_run_inc;
    logic signed [CODE_W-1:0] wval_new;
    ev_flags_t                flags;

    assign b_ready  = !out_valid_reg || out_ready;
    assign in_take  = in_valid_reg && b_ready;
    assign s_tready = !in_valid_reg || b_ready;

    assign in_valid_next = (s_tvalid && s_tready) ? 1'b1 : (in_take ? 1'b0 : in_valid_reg);

    always_comb begin
        mag      = code_mag(in_code_reg);
        high     = mag >= MAG_W'(cfg.threshold);
        starting = !active_reg && high;
        sample   = starting || (active_reg && high);
        low_path = active_reg && !high;

        // A starting item sees the freshly cleared press state.
        e_start  = starting ? in_time_reg : start_reg;
        e_count  = starting ? '0 : count_reg;
        e_peak   = starting ? in_code_reg : peak_reg;
        e_first  = starting ? in_code_reg : first_reg;
        e_marks  = starting ? '0 : marks_reg;
        e_wvalid = starting ? 1'b0 : wvalid_reg;
        e_wval   = starting ? '0 : wval_reg;
        e_ddone  = starting ? 1'b0 : ddone_reg;
        e_fill   = starting ? '0 : fill_reg;
        e_press  = starting ? press_reg + 1'b1 : press_reg;

        t = in_time_reg - e_start;

        for (int i = 0; i < MARKS; i++) begin
            mark_fire[i] = !e_marks[i] && (t >= TIME_W'(MARK_MS[i]));
        end

        win_upd = (t >= TIME_W'(cfg.win_start)) && (t <= TIME_W'(cfg.win_end)) &&
                  (!e_wvalid || (mag > code_mag(e_wval)));
        wvalid_new = e_wvalid || win_upd;
        wval_new   = win_upd ? in_code_reg : e_wval;
        disp_s     = !e_ddone && (t > TIME_W'(cfg.win_end)) && wvalid_new;

        low_run_inc = (low_run_reg != LOW_RUN_MAX) ? low_run_reg + 1'b1 : low_run_reg;
        ending      = low_path && !(low_run_inc < cfg.release_count);

        flags.start = starting;
        flags.marks = sample ? mark_fire : '0;
        flags.disp  = sample ? disp_s : (ending && !ddone_reg);
        flags.fin   = ending;

        out_bundle_next.flags        = flags;
        out_bundle_next.press_number = e_press;
        out_bundle_next.sample_code  = in_code_reg;
        out_bundle_next.disp_code    = sample ? wval_new : (wvalid_reg ? wval_reg : peak_reg);
        out_bundle_next.duration     = t;
        out_bundle_next.sample_count = count_reg;
        out_bundle_next.first_code   = first_reg;
        out_bundle_next.peak_code    = peak_reg;
        out_bundle_next.end_code     = (fill_reg == FILL_FULL) ? tap_reg[BACK_SAMPLES] : first_reg;

        active_next  = active_reg;
        press_next   = press_reg;
        start_next   = start_reg;
        count_next   = count_reg;
        first_next   = first_reg;
        peak_next    = peak_reg;
        marks_next   = marks_reg;
        wval_next    = wval_reg;
        wvalid_next  = wvalid_reg;
        ddone_next   = ddone_reg;
        low_run_next = low_run_reg;
        fill_next    = fill_reg;

        if (in_take) begin
            if (sample) begin
                active_next  = 1'b1;
                press_next   = e_press;
                start_next   = e_start;
                count_next   = e_count + 1'b1;
                first_next   = e_first;
                peak_next    = (mag > code_mag(e_peak)) ? in_code_reg : e_peak;
                marks_next   = e_marks | mark_fire;
                wval_next    = wval_new;
                wvalid_next  = wvalid_new;
                ddone_next   = e_ddone || disp_s;
                low_run_next = '0;
                fill_next    = (e_fill == FILL_FULL) ? e_fill : e_fill + 1'b1;
            end else if (low_path) begin
                low_run_next = low_run_inc;
                if (ending) begin
                    active_next = 1'b0;
                    ddone_next  = 1'b1;
                end
            end
        end

        if (in_take) begin
            out_valid_next = |flags;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            active_reg    <= 1'b0;
            press_reg     <= '0;
            start_reg     <= '0;
            count_reg     <= '0;
            first_reg     <= '0;
            peak_reg      <= '0;
            marks_reg     <= '0;
            wval_reg      <= '0;
            wvalid_reg    <= 1'b0;
            ddone_reg     <= 1'b0;
            low_run_reg   <= '0;
            fill_reg      <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            active_reg    <= active_next;
            press_reg     <= press_next;
            start_reg     <= start_next;
            count_reg     <= count_next;
            first_reg     <= first_next;
            peak_reg      <= peak_next;
            marks_reg     <= marks_next;
            wval_reg      <= wval_next;
            wvalid_reg    <= wvalid_next;
            ddone_reg     <= ddone_next;
            low_run_reg   <= low_run_next;
            fill_reg      <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_code_reg <= s_tdata[CODE_W-1:0];
            in_time_reg <= s_tdata[IN_DATA_W-1:CODE_W];
        end
        if (in_take && (|flags)) begin
            out_bundle_reg <= out_bundle_next;
        end
        // History line: newest sample at the front, the oldest kept one at the back.
        if (in_take && sample) begin
            tap_reg[0] <= in_code_reg;
            for (int i = 1; i <= BACK_SAMPLES; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_bundle = out_bundle_reg;

endmodule

`default_nettype wire

@@ src/psc_convert.sv @@
`default_nettype none

module psc_convert import psc_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire cal_cfg_t cfg,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire bundle_t in_bundle,
    output logic       out_valid,
    input  wire logic  out_ready,
    output res_bundle_t out_bundle
);

    logic                    valid_reg, valid_next;
    bundle_t                 bundle_reg;
    logic signed [SUM_W-1:0] sum_reg;

    logic signed [PROD_W-1:0]   prod;
    logic signed [SUM_W-1:0]    sum_next, rnd;
    logic signed [MV_W-1:0]     mv;
    logic [PCT_X_W-1:0]         pct_x;
    logic [PCT_PROD_W-1:0]      pct_prod;
    logic signed [VOLTS_W-1:0]  volts;
    logic [PCT_W-1:0]           pct;

    assign in_ready = !valid_reg || out_ready;

    // First stage: gain times code plus the offset at the same scale.
    assign prod     = cfg.gain_q16 * in_bundle.disp_code;
    assign sum_next = SUM_W'(prod) + (SUM_W'(cfg.offset_mv) <<< FRAC_BITS);

    always_comb begin
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            bundle_reg <= in_bundle;
            sum_reg    <= sum_next;
        end
    end

    // Second stage: round to millivolts, saturate, and scale to percent.
    always_comb begin
        rnd = sum_reg + SUM_W'(ROUND_HALF);
        mv  = rnd[SUM_W-1:FRAC_BITS];

        if (mv > MV_W'(VOLTS_MAX)) begin
            volts = VOLTS_W'(VOLTS_MAX);
        end else if (mv < MV_W'(VOLTS_MIN)) begin
            volts = VOLTS_W'(VOLTS_MIN);
        end else begin
            volts = mv[VOLTS_W-1:0];
        end

        pct_x    = PCT_X_W'(mv - MV_W'(PCT_BIAS));
        pct_prod = PCT_PROD_W'(pct_x) * PCT_PROD_W'(PCT_RECIP);
        if (mv <= MV_W'(PCT_LO_MV)) begin
            pct = '0;
        end else if (mv >= MV_W'(PCT_HI_MV)) begin
            pct = PCT_W'(PCT_FULL);
        end else begin
            pct = pct_prod[PCT_SHIFT +: PCT_W];
        end
    end

    assign out_valid           = valid_reg;
    assign out_bundle.evt      = bundle_reg;
    assign out_bundle.volts_mv = volts;
    assign out_bundle.percent  = pct;

endmodule

`default_nettype wire

@@ src/psc_serializer.sv @@
`default_nettype none

module psc_serializer import psc_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire res_bundle_t          in_bundle,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [OUT_DATA_W-1:0]     m_tdata,
    output logic [1:0]                m_tuser,
    output logic                      m_tlast
);

    localparam int PEND_W = $bits(ev_flags_t);

    logic              valid_reg, valid_next;
    logic [PEND_W-1:0] pend_reg, pend_next;
    res_bundle_t       bundle_reg;

    logic [PEND_W-1:0]        cur;
    logic                     last_one, take;
    ev_code_t                 ev;
    logic [MARK_IDX_W-1:0]    mark_idx;
    logic signed [CODE_W-1:0] value_code;
    logic                     is_disp, is_end;

    // Pending results go out lowest bit first: start, marks, display, end.
    assign cur      = pend_reg & (~pend_reg + 1'b1);
    assign last_one = (pend_reg & ~cur) == '0;
    assign take     = valid_reg && m_tready;
    assign in_ready = !valid_reg || (m_tready && last_one);

    always_comb begin
        valid_next = valid_reg;
        pend_next  = pend_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
            pend_next  = in_bundle.evt.flags;
        end else if (take) begin
            pend_next = pend_reg & ~cur;
            if (last_one) begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pend_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            bundle_reg <= in_bundle;
        end
    end

    always_comb begin
        mark_idx   = '0;
        value_code = '0;
        is_disp    = 1'b0;
        is_end     = 1'b0;
        if (pend_reg[0]) begin
            ev         = EV_START;
            value_code = bundle_reg.evt.sample_code;
        end else if (pend_reg[1]) begin
            ev         = EV_MARK;
            mark_idx   = 2'd0;
            value_code = bundle_reg.evt.sample_code;
        end else if (pend_reg[2]) begin
            ev         = EV_MARK;
            mark_idx   = 2'd1;
            value_code = bundle_reg.evt.sample_code;
        end else if (pend_reg[3]) begin
            ev         = EV_MARK;
            mark_idx   = 2'd2;
            value_code = bundle_reg.evt.sample_code;
        end else if (pend_reg[4]) begin
            ev         = EV_MARK;
            mark_idx   = 2'd3;
            value_code = bundle_reg.evt.sample_code;
        end else if (pend_reg[5]) begin
            ev         = EV_DISPLAY;
            value_code = bundle_reg.evt.disp_code;
            is_disp    = 1'b1;
        end else begin
            ev     = EV_END;
            is_end = 1'b1;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = last_one;
    assign m_tuser  = ev;
    // m_tdata from bit 0: press_number, mark_index, value_code, volts_mv, percent,
    // duration_ms, sample_count, first_code, peak_code, end_code, zero fill.
    assign m_tdata = {
        5'b0,
        is_end  ? bundle_reg.evt.end_code     : {CODE_W{1'b0}},
        is_end  ? bundle_reg.evt.peak_code    : {CODE_W{1'b0}},
        is_end  ? bundle_reg.evt.first_code   : {CODE_W{1'b0}},
        is_end  ? bundle_reg.evt.sample_count : {CNT_W{1'b0}},
        is_end  ? bundle_reg.evt.duration     : {TIME_W{1'b0}},
        is_disp ? bundle_reg.percent          : {PCT_W{1'b0}},
        is_disp ? bundle_reg.volts_mv         : {VOLTS_W{1'b0}},
        value_code,
        mark_idx,
        bundle_reg.evt.press_number
    };

endmodule

`default_nettype wire
